// File: rtl/jrd_pkg.sv
// jrd_pkg: payload types, stage map and arctangent table for the radial dead zone block.
// Depends on nothing; every rtl file but jrd_queue uses it.
`timescale 1ns / 1ps
package jrd_pkg;

  typedef struct packed {
    logic               stick_select;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_magnitude;
    logic        [15:0] heading;
  } out_t;

  // Classified request as it leaves the front
  typedef struct packed {
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic               sx;
    logic               sy;
    logic               zero;
    logic [14:0]        lo;
    logic [14:0]        hi;
    logic [30:0]        xx;
    logic [30:0]        yy;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic               zneg;
  } fe_t;

  // Back pipeline stage contents
  typedef struct packed {
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic               sx;
    logic               sy;
    logic               zero;
    logic [22:0]        lo;
    logic [22:0]        hi;
    logic [47:0]        v;
    logic [47:0]        res;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic [31:0]        cz;
    logic [15:0]        hd;
    logic [23:0]        rq;
    logic               ok;
    logic [39:0]        num;
    logic [22:0]        den;
    logic [16:0]        q;
    logic [39:0]        nx;
    logic [39:0]        ny;
    logic [15:0]        qx;
    logic [15:0]        qy;
  } bk_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } bk_ctl_t;

  typedef enum logic [1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_OUTER    = 2'd2
  } cfg_idx_t;

  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [14:0] OUTER_RST    = 15'd31129;

  localparam int CORDIC_STEPS = 20;
  localparam int SQ_LAST      = 24;
  localparam int CLAMP_ST     = 25;
  localparam int MDIV_FIRST   = 26;
  localparam int MDIV_LAST    = 42;
  localparam int MUL_ST       = 43;
  localparam int XDIV_FIRST   = 44;
  localparam int XDIV_LAST    = 59;
  localparam int N_STAGES     = 60;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

endpackage

// File: rtl/jrd_queue.sv
// jrd_queue: small register queue with push/full and pop/empty sides.
// Depends on nothing.
`timescale 1ns / 1ps
module jrd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule

// File: rtl/jrd_front.sv
// jrd_front: configuration registers and classification of a raw sample.
// Depends on jrd_pkg.
`timescale 1ns / 1ps
module jrd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [14:0]   cfg_wdata,
  input  jrd_pkg::in_t  in_data,
  output jrd_pkg::fe_t  entry
);
  import jrd_pkg::*;

  logic [14:0] lz_r, rz_r, ol_r;
  logic [16:0] xe, ye;
  logic [31:0] xx, yy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lz_r <= LEFT_DZ_RST;
      rz_r <= RIGHT_DZ_RST;
      ol_r <= OUTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DZ:  lz_r <= cfg_wdata;
        CFG_RIGHT_DZ: rz_r <= cfg_wdata;
        CFG_OUTER:    ol_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    xe = {in_data.raw_x[15], in_data.raw_x};
    ye = {in_data.raw_y[15], in_data.raw_y};
    entry.sx   = in_data.raw_x[15];
    entry.sy   = in_data.raw_y[15];
    entry.ax   = in_data.raw_x[15] ? 16'(-xe) : in_data.raw_x;
    entry.ay   = in_data.raw_y[15] ? 16'(-ye) : in_data.raw_y;
    xx         = 32'(entry.ax) * 32'(entry.ax);
    yy         = 32'(entry.ay) * 32'(entry.ay);
    entry.xx   = xx[30:0];
    entry.yy   = yy[30:0];
    entry.zero = (in_data.raw_x == '0) && (in_data.raw_y == '0);
    // fold the left half plane onto the right one
    entry.zneg = in_data.raw_x[15];
    entry.cx   = in_data.raw_x[15] ? -$signed(xe) : $signed(xe);
    entry.cy   = in_data.raw_x[15] ? -$signed(ye) : $signed(ye);
    entry.lo   = in_data.stick_select ? rz_r : lz_r;
    entry.hi   = ol_r;
  end
endmodule

// File: rtl/jrd_back.sv
// jrd_back: pipeline for square root, CORDIC heading, remap divide and rescale divides.
// Depends on jrd_pkg.
`timescale 1ns / 1ps
module jrd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jrd_pkg::bk_ctl_t ctl,
  input  jrd_pkg::fe_t    entry,
  output logic            res_vld,
  output jrd_pkg::out_t   res
);
  import jrd_pkg::*;

  bk_t  p_r   [N_STAGES];
  bk_t  p_nxt [N_STAGES];
  logic [N_STAGES-1:0] vld_r;

  function automatic bk_t load(input fe_t f);
    bk_t n;
    logic [31:0] r2;
    n     = '0;
    r2    = 32'(f.xx) + 32'(f.yy);
    n.ax  = f.ax;
    n.ay  = f.ay;
    n.sx  = f.sx;
    n.sy  = f.sy;
    n.zero = f.zero;
    n.lo  = {f.lo, 8'd0};
    n.hi  = {f.hi, 8'd0};
    n.v   = {r2, 16'd0};
    n.cx  = {{3{f.cx[16]}}, f.cx, 16'd0};
    n.cy  = {{3{f.cy[16]}}, f.cy, 16'd0};
    n.cz  = f.zneg ? 32'h8000_0000 : 32'd0;
    return n;
  endfunction

  function automatic bk_t step(input int s, input bk_t p);
    bk_t n;
    logic [47:0] b, t;
    logic signed [35:0] xs, ys;
    logic [39:0] dk;
    logic [23:0] c;
    logic [31:0] px, py;
    logic [31:0] zr;
    int k;
    n = p;
    if (s <= SQ_LAST) begin
      b = 48'd1 << (2 * (SQ_LAST - s));
      t = p.res + b;
      if (p.v >= t) begin
        n.v   = p.v - t;
        n.res = (p.res >> 1) + b;
      end else begin
        n.res = p.res >> 1;
      end
    end
    if (s <= CORDIC_STEPS) begin
      xs = p.cx >>> (s - 1);
      ys = p.cy >>> (s - 1);
      if (p.cy > 36'sd0) begin
        n.cx = p.cx + ys;
        n.cy = p.cy - xs;
        n.cz = p.cz + ATAN_TAB[s-1];
      end else begin
        n.cx = p.cx - ys;
        n.cy = p.cy + xs;
        n.cz = p.cz - ATAN_TAB[s-1];
      end
    end
    if (s == CLAMP_ST) begin
      zr   = p.cz + 32'h0000_8000;
      n.hd = p.zero ? 16'd0 : zr[31:16];
      n.rq = p.res[23:0];
      n.ok = p.hi > p.lo;
      c    = (p.res[23:0] > {1'b0, p.hi}) ? {1'b0, p.hi} : p.res[23:0];
      c    = (c < {1'b0, p.lo}) ? {1'b0, p.lo} : c;
      n.num = n.ok ? {1'b0, c[22:0] - p.lo, 16'd0} : 40'd0;
      n.den = p.hi - p.lo;
      n.q   = '0;
    end
    if (s >= MDIV_FIRST && s <= MDIV_LAST) begin
      k  = MDIV_LAST - s;
      dk = {17'd0, p.den} << k;
      if (p.num >= dk) begin
        n.num  = p.num - dk;
        n.q[k] = 1'b1;
      end
    end
    if (s == MUL_ST) begin
      // saturate full deflection to just under one
      n.q  = !p.ok ? 17'd0 : (p.q[16] ? 17'h0FFFF : p.q);
      px   = 32'(n.q[15:0]) * 32'(p.ax);
      py   = 32'(n.q[15:0]) * 32'(p.ay);
      n.nx = {1'b0, px, 7'd0};
      n.ny = {1'b0, py, 7'd0};
      n.qx = '0;
      n.qy = '0;
    end
    if (s >= XDIV_FIRST && s <= XDIV_LAST) begin
      k  = XDIV_LAST - s;
      dk = {16'd0, p.rq} << k;
      if (p.nx >= dk) begin
        n.nx    = p.nx - dk;
        n.qx[k] = 1'b1;
      end
      if (p.ny >= dk) begin
        n.ny    = p.ny - dk;
        n.qy[k] = 1'b1;
      end
    end
    return n;
  endfunction

  assign p_nxt[0] = load(entry);

  for (genvar s = 1; s < N_STAGES; s++) begin : g_st
    assign p_nxt[s] = step(s, p_r[s-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[N_STAGES-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p_r <= p_nxt;
    end
  end

  always_comb begin
    res_vld           = vld_r[N_STAGES-1];
    res.out_magnitude = p_r[N_STAGES-1].q[15:0];
    res.heading       = p_r[N_STAGES-1].hd;
    if (p_r[N_STAGES-1].rq == '0) begin
      res.out_x = '0;
      res.out_y = '0;
    end else begin
      res.out_x = p_r[N_STAGES-1].sx ? -$signed(p_r[N_STAGES-1].qx)
                                     : $signed(p_r[N_STAGES-1].qx);
      res.out_y = p_r[N_STAGES-1].sy ? -$signed(p_r[N_STAGES-1].qy)
                                     : $signed(p_r[N_STAGES-1].qy);
    end
  end
endmodule

// File: rtl/joystick_radial_deadzone_top.sv
// joystick_radial_deadzone_top: radial thumbstick dead zone with linear rescale.
// Depends on jrd_pkg, jrd_front, jrd_queue and jrd_back.
//
//   channel  ports                           moves
//   input    push, full, in_data             one raw sample request
//   result   empty, pop, out_data            one conditioned result
//   config   cfg_we, cfg_index, cfg_wdata    one register write
//
// One request per cycle sustained while the result queue has room; a request
// passes the front queue, 60 back stages and the result queue, with the 24-step
// square root, the 17-step remap divide and the 16-step rescale divides in series.
// Reset is synchronous and clears both queues and the stage valids; registers
// return to their reset values. A stalled result holds the back pipeline; the
// four-entry front queue keeps taking requests until it fills.
`timescale 1ns / 1ps
module joystick_radial_deadzone_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  jrd_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output jrd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [14:0]   cfg_wdata
);
  import jrd_pkg::*;

  fe_t     fe_in, fe_out;
  logic    mq_empty;
  logic    oq_full;
  logic    res_vld;
  out_t    res;
  bk_ctl_t ctl;

  // classify the sample and pick its dead zone
  jrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .entry     (fe_in)
  );

  // decouple the front from the back
  jrd_queue #(.W($bits(fe_t)), .DEPTH(4)) u_mq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fe_in),
    .full  (full),
    .pop   (ctl.adv),
    .rdata (fe_out),
    .empty (mq_empty)
  );

  // advance the back whenever the result queue has room
  assign ctl.adv = !oq_full;
  assign ctl.vld = !mq_empty;

  jrd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .entry   (fe_out),
    .res_vld (res_vld),
    .res     (res)
  );

  // hold finished results apart from the consumer
  jrd_queue #(.W($bits(out_t)), .DEPTH(2)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld && ctl.adv),
    .wdata (res),
    .full  (oq_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );
endmodule

// File: rtl/jrd_checker.sv
// jrd_checker: port-level assertions for the radial dead zone block, bound to the top.
// Depends on jrd_pkg and joystick_radial_deadzone_top.
`timescale 1ns / 1ps
module jrd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          push,
  input logic          full,
  input jrd_pkg::in_t  in_data,
  input logic          empty,
  input logic          pop,
  input jrd_pkg::out_t out_data,
  input logic          cfg_we,
  input logic [1:0]    cfg_index,
  input logic [14:0]   cfg_wdata
);
  a_reset: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  a_dead: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.out_magnitude == 16'd0 |-> out_data.out_x == 16'sd0
                                               && out_data.out_y == 16'sd0)
    else $error("nonzero vector with zero magnitude");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("waiting result changed");

  a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty)
    else $error("result shown right after reset");
endmodule

bind joystick_radial_deadzone_top jrd_checker u_chk (.*);
